### sv/tksk_pkg.sv
`default_nettype none
package tksk_pkg;

    localparam int K_BEST  = 16;
    localparam int MAX_OUT = 16;
    localparam int IDX_W   = (K_BEST > 1) ? $clog2(K_BEST) : 1;
    localparam int CNT_W   = $clog2(K_BEST + 1);
    localparam int RANK_W  = 4;
    localparam int ID_W    = 32;
    localparam int SCORE_W = 32;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             insert;
        logic             load;
        logic [IDX_W-1:0] rd_idx;
        logic             last;
        logic             clear;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] emit_cnt;
    } dp_stat_t;

endpackage
`default_nettype wire

### sv/tksk_dp.sv
`default_nettype none
module tksk_dp
    import tksk_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    input  wire logic [ID_W-1:0]           in_doc_id,
    input  wire logic signed [SCORE_W-1:0] in_score,
    output logic [ID_W-1:0]                out_doc_id,
    output logic signed [SCORE_W-1:0]      out_score,
    output logic [RANK_W-1:0]              out_rank,
    output logic                           out_last,
    output logic [CNT_W-1:0]               fill_count
);

    logic [ID_W-1:0]           id_reg    [K_BEST];
    logic signed [SCORE_W-1:0] score_reg [K_BEST];
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [K_BEST-1:0]         ge;
    logic                      full;
    logic                      drop;
    logic [CNT_W-1:0]          top;

    logic [ID_W-1:0]           out_id_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic [RANK_W-1:0]         out_rank_reg;
    logic                      out_last_reg;

    assign full = (fill_reg == CNT_W'(K_BEST));
    assign drop = full && ge[K_BEST-1];
    assign top  = full ? CNT_W'(K_BEST - 1) : fill_reg;

    genvar i;
    generate
        for (i = 0; i < K_BEST; i++) begin : g_slot
            localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);

            assign ge[i] = (SLOT < fill_reg) && (score_reg[i] >= in_score);

            if (i == 0) begin : g_head
                always_ff @(posedge aclk) begin
                    if (cmd.insert && !drop && !ge[i]) begin
                        id_reg[i]    <= in_doc_id;
                        score_reg[i] <= in_score;
                    end
                end
            end else begin : g_body
                always_ff @(posedge aclk) begin
                    if (cmd.insert && !drop && (SLOT <= top) && !ge[i]) begin
                        if (ge[i-1]) begin
                            id_reg[i]    <= in_doc_id;
                            score_reg[i] <= in_score;
                        end else begin
                            id_reg[i]    <= id_reg[i-1];
                            score_reg[i] <= score_reg[i-1];
                        end
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear) begin
            fill_next = '0;
        end else if (cmd.insert && !full) begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_id_reg    <= id_reg[cmd.rd_idx];
            out_score_reg <= score_reg[cmd.rd_idx];
            out_rank_reg  <= RANK_W'(cmd.rd_idx);
            out_last_reg  <= cmd.last;
        end
    end

    assign stat.emit_cnt = (fill_reg > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : fill_reg;

    assign out_doc_id = out_id_reg;
    assign out_score  = out_score_reg;
    assign out_rank   = out_rank_reg;
    assign out_last   = out_last_reg;
    assign fill_count = fill_reg;

endmodule
`default_nettype wire

### sv/tksk_ctrl.sv
`default_nettype none
module tksk_ctrl
    import tksk_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_final_item,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             slot_free;
    logic             is_last;

    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || m_ready;
    assign is_last   = (CNT_W'(idx_reg) == (stat.emit_cnt - CNT_W'(1)));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_final_item) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.insert = accept;
                idx_next   = '0;
            end
            ST_EMIT: begin
                cmd.rd_idx = idx_reg;
                cmd.last   = is_last;
                if (slot_free) begin
                    cmd.load       = 1'b1;
                    cmd.clear      = is_last;
                    out_valid_next = 1'b1;
                    idx_next       = is_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

### sv/top_k_score_keeper_core.sv
// Top-K score keeper: keeps the best K_BEST (16) candidates by descending score.
// Input channel s_*: one candidate (doc id, signed Q16.16 score, final flag)
// per transaction. While collecting, a candidate is taken every cycle; all
// slots compare against it in parallel and shift together as it is taken.
// Ties keep arrival order; a tie with the minimum of a full list is dropped.
// A candidate with s_final_item set is inserted, then the kept list is sent
// on the m_* channel best first, one entry per transaction, rank 0 first,
// with m_last_of_run on the final entry; the list is then cleared.
// After the final candidate is accepted, the controller enters ST_EMIT and loads
// the first entry into the output register when it is free. Emission reads one
// kept entry (1 to 16) at a time via the single read port on the kept list;
// s_ready is low meanwhile. A stall on m_ready holds the output register and
// pauses emission. Input is taken again once the last entry is loaded into the
// output register, even if that entry is still waiting.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// output; no clearing pass is needed.
`default_nettype none
module top_k_score_keeper_core
    import tksk_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ID_W-1:0]           s_doc_id,
    input  wire logic signed [SCORE_W-1:0] s_score,
    input  wire logic                      s_final_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ID_W-1:0]                m_best_doc_id,
    output logic signed [SCORE_W-1:0]      m_best_score,
    output logic [RANK_W-1:0]              m_rank,
    output logic                           m_last_of_run
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [CNT_W-1:0] fill_count;

    tksk_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_final_item (s_final_item),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    tksk_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_doc_id  (s_doc_id),
        .in_score   (s_score),
        .out_doc_id (m_best_doc_id),
        .out_score  (m_best_score),
        .out_rank   (m_rank),
        .out_last   (m_last_of_run),
        .fill_count (fill_count)
    );

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count <= CNT_W'(K_BEST))
        else $error("kept list count exceeds capacity");

    a_final_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_item) |=> !s_ready)
        else $error("input taken during emission");

    a_final_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_item) |=> (fill_count != '0))
        else $error("empty list after final candidate");

    a_first_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_item && !(m_valid && !m_ready))
        |=> ##1 (m_valid && m_rank == '0))
        else $error("emission does not start at rank zero");
`endif

endmodule
`default_nettype wire
